[rtl/vnn_pkg.sv]
// Package with the shared types and constants of the vector normalizer.
`default_nettype none
package vnn_pkg;

  localparam int MAX_LEN_DEF      = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ACC_W            = 37;
  localparam int NORM_FRAC        = 8;
  localparam int Q_FRAC           = 15;
  localparam int NORM_W           = ACC_W + NORM_FRAC;
  localparam int ROOT_W           = ACC_W + 2 * NORM_FRAC;
  localparam int Q_W              = 17;
  localparam int QBITS            = 16;
  localparam int OUT_W            = 16;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic [ACC_W-1:0] ACC_LIM = '1;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_L1   = 2'd1;
  localparam logic [1:0] MODE_L2   = 2'd2;
  localparam logic [1:0] MODE_INF  = 2'd3;
  localparam logic [1:0] MODE_RST  = MODE_L2;

  localparam logic REG_NORM_MODE = 1'b0;

  typedef enum logic [3:0] {
    S_LOAD, S_ACC_RD, S_ACC_MUL, S_ACC_ADD, S_SQRT_INIT, S_SQRT, S_NORM,
    S_EMIT_RD, S_PREP, S_DIV, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic ld;
    logic idx_clr;
    logic idx_inc;
    logic mul;
    logic add;
    logic sqrt_init;
    logic sqrt_step;
    logic norm_ld;
    logic prep;
    logic div_step;
    logic fin;
    logic vec_clr;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic is_l2;
    logic bypass;
    logic sqrt_done;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

[rtl/vnn_ctrl.sv]
// Controller state machine of the vector normalizer.
`default_nettype none
module vnn_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  wire              in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  input  vnn_pkg::sts_t    sts,
  output vnn_pkg::cmd_t    cmd
);

  vnn_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vnn_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vnn_pkg::S_LOAD: begin
        if (in_valid && in_last) state_nxt = vnn_pkg::S_ACC_RD;
      end
      vnn_pkg::S_ACC_RD:  state_nxt = vnn_pkg::S_ACC_MUL;
      vnn_pkg::S_ACC_MUL: state_nxt = vnn_pkg::S_ACC_ADD;
      vnn_pkg::S_ACC_ADD: begin
        if (!sts.idx_last) state_nxt = vnn_pkg::S_ACC_RD;
        else if (sts.is_l2) state_nxt = vnn_pkg::S_SQRT_INIT;
        else state_nxt = vnn_pkg::S_NORM;
      end
      vnn_pkg::S_SQRT_INIT: state_nxt = vnn_pkg::S_SQRT;
      vnn_pkg::S_SQRT: begin
        if (sts.sqrt_done) state_nxt = vnn_pkg::S_NORM;
      end
      vnn_pkg::S_NORM:    state_nxt = vnn_pkg::S_EMIT_RD;
      vnn_pkg::S_EMIT_RD: state_nxt = vnn_pkg::S_PREP;
      vnn_pkg::S_PREP: begin
        state_nxt = sts.bypass ? vnn_pkg::S_FIN : vnn_pkg::S_DIV;
      end
      vnn_pkg::S_DIV: begin
        if (sts.div_done) state_nxt = vnn_pkg::S_FIN;
      end
      vnn_pkg::S_FIN: state_nxt = vnn_pkg::S_OUT;
      vnn_pkg::S_OUT: begin
        if (out_ready) begin
          state_nxt = sts.idx_last ? vnn_pkg::S_LOAD : vnn_pkg::S_EMIT_RD;
        end
      end
      default: state_nxt = vnn_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      vnn_pkg::S_LOAD: begin
        in_ready    = 1'b1;
        cmd.ld      = in_valid;
        cmd.idx_clr = in_valid && in_last;
      end
      vnn_pkg::S_ACC_MUL: cmd.mul = 1'b1;
      vnn_pkg::S_ACC_ADD: begin
        cmd.add     = 1'b1;
        cmd.idx_inc = !sts.idx_last;
      end
      vnn_pkg::S_SQRT_INIT: cmd.sqrt_init = 1'b1;
      vnn_pkg::S_SQRT:      cmd.sqrt_step = 1'b1;
      vnn_pkg::S_NORM: begin
        cmd.norm_ld = 1'b1;
        cmd.idx_clr = 1'b1;
      end
      vnn_pkg::S_PREP: cmd.prep     = 1'b1;
      vnn_pkg::S_DIV:  cmd.div_step = 1'b1;
      vnn_pkg::S_FIN:  cmd.fin      = 1'b1;
      vnn_pkg::S_OUT: begin
        out_valid   = 1'b1;
        cmd.idx_inc = out_ready && !sts.idx_last;
        cmd.vec_clr = out_ready && sts.idx_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/vnn_dpath.sv]
// Datapath of the vector normalizer: element store, norm, square root and divider.
`default_nettype none
module vnn_dpath #(
  parameter int MAX_LEN      = vnn_pkg::MAX_LEN_DEF,
  parameter int SAMPLE_WIDTH = vnn_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  [SAMPLE_WIDTH-1:0]       in_sample,
  input  wire                           in_last,
  input  wire  [1:0]                    cfg_mode,
  input  vnn_pkg::cmd_t                 cmd,
  output vnn_pkg::sts_t                 sts,
  output logic [vnn_pkg::OUT_W-1:0]     out_value,
  output logic                          out_end_of_vector
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int SUM_W  = ((2 * SW > vnn_pkg::ACC_W) ? 2 * SW : vnn_pkg::ACC_W) + 1;
  localparam int SHIFT  = vnn_pkg::Q_FRAC + vnn_pkg::NORM_FRAC + 1;
  localparam int NW     = ((SW + SHIFT > vnn_pkg::NORM_W) ? SW + SHIFT : vnn_pkg::NORM_W) + 1;
  localparam int DW     = NW + vnn_pkg::QBITS;
  localparam int BW     = SW + vnn_pkg::Q_FRAC;
  localparam int ACC_W  = vnn_pkg::ACC_W;
  localparam int ROOT_W = vnn_pkg::ROOT_W;
  localparam int NORM_W = vnn_pkg::NORM_W;
  localparam int Q_W    = vnn_pkg::Q_W;
  localparam int OUT_W  = vnn_pkg::OUT_W;

  logic [SW-1:0]     mem [MAX_LEN];
  logic [SW-1:0]     rd_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  idx_r;
  logic [1:0]        mode_r;
  logic [SW-1:0]     mag_r;
  logic [2*SW-1:0]   sq_r;
  logic [ACC_W-1:0]  acc_r;
  logic [ROOT_W-1:0] v_r, root_r, bit_r;
  logic [NORM_W-1:0] norm_r;
  logic [NW-1:0]     rem_r;
  logic [DW-1:0]     dsh_r;
  logic [Q_W-1:0]    q_r;
  logic [vnn_pkg::QBITS-1:0] qbit_r;
  logic              sign_r;

  logic [SW-1:0]     rd_mag;
  logic [SUM_W-1:0]  sum;
  logic [ROOT_W-1:0] sq_try;
  logic [NW-1:0]     nn, den;
  logic [BW-1:0]     wide;
  logic [Q_W-1:0]    q_byp;
  logic              byp;

  assign rd_mag = rd_r[SW-1] ? (SW'(0) - rd_r) : rd_r;
  assign byp    = (mode_r == vnn_pkg::MODE_NONE) || (norm_r == '0);
  assign nn     = NW'({rd_mag, {(SHIFT){1'b0}}}) + NW'(norm_r);
  assign den    = NW'({norm_r, 1'b0});
  assign wide   = (mode_r == vnn_pkg::MODE_NONE) ? BW'(rd_mag)
                                                 : {rd_mag, {(vnn_pkg::Q_FRAC){1'b0}}};
  assign q_byp  = ((wide >> Q_W) != '0) ? '1 : wide[Q_W-1:0];
  assign sq_try = root_r + bit_r;

  always_comb begin
    sum = SUM_W'(acc_r);
    if (mode_r == vnn_pkg::MODE_L1) sum = SUM_W'(acc_r) + SUM_W'(mag_r);
    else if (mode_r == vnn_pkg::MODE_L2) sum = SUM_W'(acc_r) + SUM_W'(sq_r);
  end

  assign sts.idx_last  = (CNT_W'(idx_r) + CNT_W'(1)) == cnt_r;
  assign sts.is_l2     = mode_r == vnn_pkg::MODE_L2;
  assign sts.bypass    = byp;
  assign sts.sqrt_done = bit_r[0];
  assign sts.div_done  = qbit_r[0];

  always_ff @(posedge clk) begin
    if (cmd.ld && (cnt_r < CNT_W'(MAX_LEN))) begin
      mem[cnt_r[IDX_W-1:0]] <= in_sample;
    end
    rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      acc_r  <= '0;
      mode_r <= vnn_pkg::MODE_RST;
      idx_r  <= '0;
      bit_r  <= '0;
      qbit_r <= '0;
    end else begin
      if (cmd.ld) begin
        if (cnt_r < CNT_W'(MAX_LEN)) cnt_r <= cnt_r + CNT_W'(1);
        if (in_last) mode_r <= cfg_mode;
      end
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + IDX_W'(1);
      if (cmd.vec_clr) begin
        cnt_r <= '0;
        acc_r <= '0;
      end else if (cmd.add) begin
        if (mode_r == vnn_pkg::MODE_INF) begin
          if (SUM_W'(mag_r) > SUM_W'(acc_r)) acc_r <= ACC_W'(mag_r);
        end else begin
          acc_r <= (sum > SUM_W'(vnn_pkg::ACC_LIM)) ? vnn_pkg::ACC_LIM : sum[ACC_W-1:0];
        end
      end
      if (cmd.sqrt_init) bit_r <= ROOT_W'(1) << (ROOT_W - 1);
      else if (cmd.sqrt_step) bit_r <= bit_r >> 2;
      if (cmd.prep) qbit_r <= vnn_pkg::QBITS'(1) << (vnn_pkg::QBITS - 1);
      else if (cmd.div_step) qbit_r <= qbit_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      mag_r <= rd_mag;
      sq_r  <= rd_mag * rd_mag;
    end
    if (cmd.sqrt_init) begin
      v_r    <= {acc_r, {(2 * vnn_pkg::NORM_FRAC){1'b0}}};
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      if (v_r >= sq_try) begin
        v_r    <= v_r - sq_try;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
    end
    if (cmd.norm_ld) begin
      norm_r <= (mode_r == vnn_pkg::MODE_L2) ? root_r[NORM_W-1:0]
                                              : {acc_r, {(vnn_pkg::NORM_FRAC){1'b0}}};
    end
    if (cmd.prep) begin
      sign_r <= rd_r[SW-1];
      rem_r  <= nn;
      dsh_r  <= DW'(den) << (vnn_pkg::QBITS - 1);
      if (byp) q_r <= q_byp;
      else q_r <= (DW'(nn) >= (DW'(den) << vnn_pkg::QBITS)) ? '1 : '0;
    end else if (cmd.div_step) begin
      if (DW'(rem_r) >= dsh_r) begin
        rem_r <= rem_r - NW'(dsh_r);
        q_r   <= q_r | Q_W'(qbit_r);
      end
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.fin) begin
      out_end_of_vector <= sts.idx_last;
      if (sign_r) begin
        out_value <= (q_r > Q_W'(32768)) ? 16'h8000 : OUT_W'(Q_W'(0) - q_r);
      end else begin
        out_value <= (q_r > Q_W'(32767)) ? 16'h7fff : q_r[OUT_W-1:0];
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_LEN)) else $error("element count beyond store depth");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld && !cmd.vec_clr && cnt_r == CNT_W'(MAX_LEN)) |=> $stable(cnt_r))
    else $error("store full but count moved");
  a_qbit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(qbit_r)) else $error("divider step marker corrupted");
  a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bit_r)) else $error("square root step marker corrupted");

endmodule
`default_nettype wire

[rtl/vector_norm_normalizer_core.sv]
// Top level of the vector normalizer: configuration register, controller and datapath.
//
//   port group   direction   contents
//   in_          sink        in_sample, in_last (valid/ready)
//   out_         source      out_value, out_end_of_vector (valid/ready)
//   APB          slave       psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Loading takes one word per cycle while no earlier vector is still being processed.
// Then the norm sweep reads, multiplies and adds each stored element; the bit-serial
// square root runs in L2 mode and the norm is formed. Each result takes read and prep
// steps, the restoring divider (skipped in mode none or for a zero norm), a final step
// and any output stall. Synchronous reset clears count and accumulator; mode resets to L2.
`default_nettype none
module vector_norm_normalizer_core #(
  parameter int MAX_LEN      = vnn_pkg::MAX_LEN_DEF,
  parameter int SAMPLE_WIDTH = vnn_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [SAMPLE_WIDTH-1:0]          in_sample,
  input  wire                              in_last,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [vnn_pkg::OUT_W-1:0]        out_value,
  output logic                             out_end_of_vector,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [vnn_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire  [vnn_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [vnn_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  logic [1:0]    norm_mode_r;
  vnn_pkg::cmd_t cmd;
  vnn_pkg::sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == vnn_pkg::REG_NORM_MODE)
                  ? vnn_pkg::CFG_DATA_W'(norm_mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_mode_r <= vnn_pkg::MODE_RST;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == vnn_pkg::REG_NORM_MODE) begin
      norm_mode_r <= pwdata[1:0];
    end
  end

  vnn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vnn_dpath #(
    .MAX_LEN      (MAX_LEN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_sample         (in_sample),
    .in_last           (in_last),
    .cfg_mode          (norm_mode_r),
    .cmd               (cmd),
    .sts               (sts),
    .out_value         (out_value),
    .out_end_of_vector (out_end_of_vector)
  );

endmodule
`default_nettype wire
